>>> hw/rtl/dra_pkg.sv
// Shared codes and field widths for the descriptor range allocator.
package dra_pkg;

	localparam int CmdW     = 1;
	localparam int HeapW    = 3;
	localparam int SlotW    = 10;
	localparam int OffsetW  = 18;
	localparam int StatusW  = 2;
	localparam int SphW     = 11;
	localparam int StrideW  = 9;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 11;
	localparam int StrideMax = 256;

	typedef enum logic [CmdW-1:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_HEAP = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	localparam logic [CfgIdxW-1:0] CFG_SLOTS  = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_STRIDE = 1'b1;

endpackage

>>> hw/rtl/dra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dra_ram #(
	parameter int Width = 22,
	parameter int Depth = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                      wdata,
	input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                      rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/descriptor_range_allocator.sv
// Top level of the descriptor range allocator: sequencer, counters and range store.
//
// Usage: each input word (cmd, free_heap, free_slot) is an allocate or a free
// command, taken on in_valid & in_ready. Exactly one result word (status,
// heap_index, slot_index, byte_offset, heap_opened) follows on out_valid /
// out_ready. Config words (cfg_index, cfg_data) write slots_per_heap (index 0)
// or descriptor_stride (index 1); cfg_ready is always high.
// Sequencing: one command at a time, in_ready is high only while idle.
//   Allocate: scan the open heaps in order (opening a new heap if none has a
//   range); for a found heap, read and update the first range, move each
//   remaining range down when that range empties, then load the result.
//   Free: walk the ranges; merge into an adjacent range, or move ranges up on
//   an insert and place the new range (or append it), then load the result.
// The range store is one RAM with one read and one write port; every walk
// and shift step goes through its registered read.
// Reset clears open_heaps and all range counts and restores the register
// defaults (256 slots, 32-byte stride); the store needs no clearing pass.
// When the receiver stalls, the result holds in the output register; a
// finished command waits for it to drain before loading its own result.
module descriptor_range_allocator #(
	parameter int MAX_HEAPS  = 8,
	parameter int MAX_RANGES = 16,
	parameter int MAX_SLOTS  = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dra_pkg::CmdW-1:0]     cmd,
	input  logic [dra_pkg::HeapW-1:0]    free_heap,
	input  logic [dra_pkg::SlotW-1:0]    free_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dra_pkg::StatusW-1:0]  status,
	output logic [dra_pkg::HeapW-1:0]    heap_index,
	output logic [dra_pkg::SlotW-1:0]    slot_index,
	output logic [dra_pkg::OffsetW-1:0]  byte_offset,
	output logic                         heap_opened,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dra_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dra_pkg::CfgDataW-1:0] cfg_data
);
	import dra_pkg::*;

	localparam int HW   = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
	localparam int HCW  = $clog2(MAX_HEAPS + 1);
	localparam int IW   = $clog2(MAX_RANGES + 1);
	localparam int RW0  = $clog2(MAX_SLOTS + 1);
	localparam int RW   = (RW0 > SphW) ? RW0 : SphW;
	localparam int Depth = MAX_HEAPS * MAX_RANGES;
	localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int MulW = SlotW + StrideW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_A_RD, ST_A_WT, ST_D_RD, ST_D_WT,
		ST_F_RD, ST_F_WT, ST_I_RD, ST_I_WT, ST_DONE
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [HW-1:0]       heap_q;
	logic [HCW-1:0]      hscan_q;
	logic [RW-1:0]       fs_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       n_q;
	logic [IW-1:0]       pos_q;
	status_t             status_q;
	logic [RW-1:0]       slot_q;
	logic                opened_q;
	logic [HCW-1:0]      open_heaps_q;
	logic [IW-1:0]       cnt_q [MAX_HEAPS];
	logic [SphW-1:0]     sph_q;
	logic [StrideW-1:0]  stride_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [2*RW-1:0]     ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [2*RW-1:0]     ram_rdata;

	logic [AW-1:0]       base;
	logic [AW-1:0]       scan_base;
	logic [RW-1:0]       rd_begin;
	logic [RW-1:0]       rd_limit;
	logic [RW-1:0]       fs_next;
	logic [RW-1:0]       new_slots;
	logic [RW-1:0]       sph_ext;
	logic [StrideW-1:0]  stride_cl;
	logic [MulW-1:0]     offset_full;
	logic [HW+HeapW-1:0] fh_ext;
	logic [HCW+HeapW-1:0] fh_cmp;
	logic [HCW+HeapW-1:0] open_cmp;
	logic [HW+HeapW-1:0] heap_out;
	logic                fh_open;
	logic [IW-1:0]       cnt_heap;
	logic [IW-1:0]       cnt_scan;

	dra_ram #(
		.Width(2 * RW),
		.Depth(Depth)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// decode addresses, fields and clamped config
	always_comb begin
		base      = AW'(heap_q * MAX_RANGES);
		scan_base = AW'(hscan_q[HW-1:0] * MAX_RANGES);
		rd_begin  = ram_rdata[2*RW-1:RW];
		rd_limit  = ram_rdata[RW-1:0];
		fs_next   = fs_q + RW'(1);
		sph_ext   = RW'(sph_q);
		if (sph_ext == '0) begin
			new_slots = RW'(1);
		end else if (sph_ext > RW'(MAX_SLOTS)) begin
			new_slots = RW'(MAX_SLOTS);
		end else begin
			new_slots = sph_ext;
		end
		stride_cl   = (stride_q > StrideW'(StrideMax)) ? StrideW'(StrideMax) : stride_q;
		offset_full = MulW'(slot_q[SlotW-1:0]) * MulW'(stride_cl);
		fh_ext   = {{HW{1'b0}}, free_heap};
		fh_cmp   = {{HCW{1'b0}}, free_heap};
		open_cmp = {{HeapW{1'b0}}, open_heaps_q};
		fh_open  = fh_cmp < open_cmp;
		heap_out = {{HeapW{1'b0}}, heap_q};
		cnt_heap = cnt_q[heap_q];
		cnt_scan = cnt_q[hscan_q[HW-1:0]];
	end

	// drive the range store from the sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = base;
		ram_wdata = ram_rdata;
		ram_raddr = base + AW'(idx_q);
		case (state_q)
			ST_SCAN: begin
				if (hscan_q == open_heaps_q && open_heaps_q < HCW'(MAX_HEAPS)) begin
					ram_we    = 1'b1;
					ram_waddr = scan_base;
					ram_wdata = {RW'(1), new_slots};
				end
			end
			ST_A_WT: begin
				if (rd_begin + RW'(1) != rd_limit) begin
					ram_we    = 1'b1;
					ram_wdata = {rd_begin + RW'(1), rd_limit};
				end
			end
			ST_D_WT: begin
				ram_we    = 1'b1;
				ram_waddr = base + AW'(idx_q) - AW'(1);
			end
			ST_F_WT: begin
				if (rd_begin == fs_next) begin
					ram_we    = 1'b1;
					ram_waddr = base + AW'(idx_q);
					ram_wdata = {fs_q, rd_limit};
				end else if (rd_limit == fs_q) begin
					ram_we    = 1'b1;
					ram_waddr = base + AW'(idx_q);
					ram_wdata = {rd_begin, fs_next};
				end
			end
			ST_I_RD: begin
				ram_raddr = base + AW'(idx_q) - AW'(1);
				if (idx_q <= pos_q) begin
					ram_we    = 1'b1;
					ram_waddr = base + AW'(pos_q);
					ram_wdata = {fs_q, fs_next};
				end
			end
			ST_I_WT: begin
				ram_we    = 1'b1;
				ram_waddr = base + AW'(idx_q);
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			open_heaps_q <= '0;
			for (int h = 0; h < MAX_HEAPS; h++) begin
				cnt_q[h] <= '0;
			end
			sph_q       <= SphW'(256);
			stride_q    <= StrideW'(32);
			out_valid   <= 1'b0;
			cmd_q       <= CMD_ALLOC;
			status_q    <= STAT_OK;
			opened_q    <= 1'b0;
			heap_q      <= '0;
			hscan_q     <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			pos_q       <= '0;
			fs_q        <= '0;
			slot_q      <= '0;
			status      <= '0;
			heap_index  <= '0;
			slot_index  <= '0;
			byte_offset <= '0;
			heap_opened <= 1'b0;
		end else begin
			// take config words
			if (cfg_valid) begin
				if (cfg_index == CFG_SLOTS) begin
					sph_q <= cfg_data;
				end else if (cfg_index == CFG_STRIDE) begin
					stride_q <= cfg_data[StrideW-1:0];
				end
			end
			// drop the result once taken, unless a new one loads now
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q    <= cmd_t'(cmd);
						fs_q     <= RW'(free_slot);
						status_q <= STAT_OK;
						opened_q <= 1'b0;
						slot_q   <= '0;
						hscan_q  <= '0;
						idx_q    <= '0;
						heap_q   <= fh_ext[HW-1:0];
						n_q      <= cnt_q[fh_ext[HW-1:0]];
						if (cmd_t'(cmd) == CMD_ALLOC) begin
							state_q <= ST_SCAN;
						end else if (fh_open) begin
							state_q <= ST_F_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				// look for the lowest heap with a free range, else open one
				ST_SCAN: begin
					if (hscan_q < open_heaps_q) begin
						if (cnt_scan != '0) begin
							heap_q  <= hscan_q[HW-1:0];
							state_q <= ST_A_RD;
						end else begin
							hscan_q <= hscan_q + HCW'(1);
						end
					end else if (open_heaps_q >= HCW'(MAX_HEAPS)) begin
						status_q <= STAT_NO_HEAP;
						state_q  <= ST_DONE;
					end else begin
						heap_q       <= hscan_q[HW-1:0];
						cnt_q[hscan_q[HW-1:0]] <= (new_slots == RW'(1)) ? '0 : IW'(1);
						open_heaps_q <= open_heaps_q + HCW'(1);
						opened_q     <= 1'b1;
						slot_q       <= '0;
						state_q      <= ST_DONE;
					end
				end
				ST_A_RD: begin
					state_q <= ST_A_WT;
				end
				// take the first slot; drop the range when it empties
				ST_A_WT: begin
					slot_q <= rd_begin;
					if (rd_begin + RW'(1) == rd_limit) begin
						if (cnt_heap == IW'(1)) begin
							cnt_q[heap_q] <= '0;
							state_q <= ST_DONE;
						end else begin
							idx_q   <= IW'(1);
							state_q <= ST_D_RD;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_D_RD: begin
					state_q <= ST_D_WT;
				end
				// move each range down by one
				ST_D_WT: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q + IW'(1) < cnt_heap) begin
						state_q <= ST_D_RD;
					end else begin
						cnt_q[heap_q] <= cnt_heap - IW'(1);
						state_q <= ST_DONE;
					end
				end
				// walk the list or fall through to append
				ST_F_RD: begin
					if (idx_q < n_q) begin
						state_q <= ST_F_WT;
					end else if (n_q >= IW'(MAX_RANGES)) begin
						status_q <= STAT_FULL;
						state_q  <= ST_DONE;
					end else begin
						pos_q   <= n_q;
						idx_q   <= n_q;
						state_q <= ST_I_RD;
					end
				end
				ST_F_WT: begin
					if (rd_begin == fs_next || rd_limit == fs_q) begin
						state_q <= ST_DONE;
					end else if (rd_begin > fs_q) begin
						if (n_q >= IW'(MAX_RANGES)) begin
							status_q <= STAT_FULL;
							state_q  <= ST_DONE;
						end else begin
							pos_q   <= idx_q;
							idx_q   <= n_q;
							state_q <= ST_I_RD;
						end
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_F_RD;
					end
				end
				// shift up from the tail, then place the new range
				ST_I_RD: begin
					if (idx_q > pos_q) begin
						state_q <= ST_I_WT;
					end else begin
						cnt_q[heap_q] <= cnt_heap + IW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_I_WT: begin
					idx_q   <= idx_q - IW'(1);
					state_q <= ST_I_RD;
				end
				// load the result once the output register is free
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status    <= status_q;
						if (cmd_q == CMD_ALLOC && status_q == STAT_OK) begin
							heap_index  <= heap_out[HeapW-1:0];
							slot_index  <= slot_q[SlotW-1:0];
							byte_offset <= offset_full[OffsetW-1:0];
							heap_opened <= opened_q;
						end else begin
							heap_index  <= '0;
							slot_index  <= '0;
							byte_offset <= '0;
							heap_opened <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_heaps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_heaps_q <= HCW'(MAX_HEAPS))
		else $error("open heap count beyond limit");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_heap <= IW'(MAX_RANGES))
		else $error("range count beyond limit");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !ram_we)
		else $error("range store written outside a command");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted command left sequencer idle");
	a_opened_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && heap_opened) |-> (status == STAT_OK))
		else $error("heap opened flag with error status");
`endif
endmodule
